// ----- design/jdsd_pkg.sv -----
// Package for the joystick direction and speed decoder.
// Holds the field types, result codes, register indexes and reset values.
// No dependencies; every other design file depends on it.
package jdsd_pkg;

   // Fixed field widths
   localparam int DIR_BITS       = 3;
   localparam int SPEED_BITS     = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;
   localparam int DEAD_ZONE_BITS = 7;
   localparam int LIMIT_BITS     = 8;
   localparam int LIMIT_SQ_BITS  = 2 * LIMIT_BITS;

   typedef logic [DIR_BITS-1:0]       dir_type;
   typedef logic [SPEED_BITS-1:0]     speed_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;

   // Direction codes, counterclockwise from right
   localparam dir_type DIR_RIGHT      = 3'd0;
   localparam dir_type DIR_UP_RIGHT   = 3'd1;
   localparam dir_type DIR_UP         = 3'd2;
   localparam dir_type DIR_UP_LEFT    = 3'd3;
   localparam dir_type DIR_LEFT       = 3'd4;
   localparam dir_type DIR_DOWN_LEFT  = 3'd5;
   localparam dir_type DIR_DOWN       = 3'd6;
   localparam dir_type DIR_DOWN_RIGHT = 3'd7;

   // Speed band codes
   localparam speed_type SPEED_SLOW   = 2'd0;
   localparam speed_type SPEED_MIDDLE = 2'd1;
   localparam speed_type SPEED_FAST   = 2'd2;

   // Register indexes
   localparam csr_index_type REG_NOMINAL_CENTER = 2'd0;
   localparam csr_index_type REG_DEAD_ZONE      = 2'd1;
   localparam csr_index_type REG_SLOW_LIMIT     = 2'd2;
   localparam csr_index_type REG_MIDDLE_LIMIT   = 2'd3;

   // Reset values
   localparam int CENTER_RESET    = 125;
   localparam int DEAD_ZONE_RESET = 5;
   localparam int SLOW_RESET      = 33;
   localparam int MIDDLE_RESET    = 66;

endpackage

// ----- design/jdsd_ifs.sv -----
// Valid/ready channel interfaces for the joystick decoder.
// jdsd_req_if carries one sample, jdsd_rsp_if carries one result.
// Depends on jdsd_pkg for the result field types.
interface jdsd_req_if #(
   parameter int COORD_BITS = 8
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] x_pos;
   logic [COORD_BITS-1:0] y_pos;

   modport source (output valid, output x_pos, output y_pos, input ready);
   modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

interface jdsd_rsp_if ();
   logic               valid;
   logic               ready;
   jdsd_pkg::dir_type   direction;
   jdsd_pkg::speed_type speed_band;

   modport source (output valid, output direction, output speed_band, input ready);
   modport sink   (input valid, input direction, input speed_band, output ready);
endinterface

// ----- design/joystick_direction_speed_decoder_top.sv -----
// Joystick direction and speed decoder: takes one (x_pos, y_pos) sample per
// cycle unless stalled and, for a sample outside the dead zone, returns an
// eight-way direction measured from the stored reference center and a
// slow/middle/fast speed band measured from the nominal center. A sample inside
// the dead zone becomes the new reference center and gives no result. The block
// is a three-register pipeline (input, squares, result) and accepts one item
// every cycle, and backpressure on the result channel stalls the stages behind
// it one by one. The user must write registers through the csr_ port only while
// no item is in flight; the block does not enforce this. There is no read-back.
// Depends on jdsd_pkg and the channel interfaces in jdsd_ifs.sv.
module joystick_direction_speed_decoder_top #(
   parameter int COORD_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  jdsd_pkg::csr_index_type csr_index,
   input  jdsd_pkg::csr_data_type  csr_wdata,
   jdsd_req_if.sink                req_if,
   jdsd_rsp_if.source              rsp_if
);
   import jdsd_pkg::*;

   localparam int NC_BITS  = (COORD_BITS < LIMIT_BITS) ? COORD_BITS : LIMIT_BITS;
   localparam int DZ_CMP   = (COORD_BITS > DEAD_ZONE_BITS) ? COORD_BITS : DEAD_ZONE_BITS;
   localparam int SUM_BITS = COORD_BITS + 1;
   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int S_BITS   = 2 * SUM_BITS;
   localparam int MAG_BITS = SQ_BITS + 1;
   localparam int CMP_BITS = (S_BITS > LIMIT_SQ_BITS) ? S_BITS : LIMIT_SQ_BITS;

   localparam logic [NC_BITS-1:0]       NC_RESET   = NC_BITS'(CENTER_RESET);
   localparam logic [COORD_BITS-1:0]    REF_RESET  = COORD_BITS'(CENTER_RESET);
   localparam logic [LIMIT_SQ_BITS-1:0] SLOW_SQ_RESET   = LIMIT_SQ_BITS'(SLOW_RESET * SLOW_RESET);
   localparam logic [LIMIT_SQ_BITS-1:0] MIDDLE_SQ_RESET =
      LIMIT_SQ_BITS'(MIDDLE_RESET * MIDDLE_RESET);

   // ------------------------------------------------------------------
   // Configuration registers; limits are kept squared
   // ------------------------------------------------------------------
   logic [NC_BITS-1:0]        nominal_center_ff;
   logic [DEAD_ZONE_BITS-1:0] dead_zone_ff;
   logic [LIMIT_SQ_BITS-1:0]  slow_sq_ff;
   logic [LIMIT_SQ_BITS-1:0]  middle_sq_ff;
   logic [LIMIT_SQ_BITS-1:0]  limit_sq_in;

   assign limit_sq_in = LIMIT_SQ_BITS'(csr_wdata) * LIMIT_SQ_BITS'(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_center_ff <= NC_RESET;
         dead_zone_ff      <= DEAD_ZONE_BITS'(DEAD_ZONE_RESET);
         slow_sq_ff        <= SLOW_SQ_RESET;
         middle_sq_ff      <= MIDDLE_SQ_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_NOMINAL_CENTER: nominal_center_ff <= NC_BITS'(csr_wdata);
            REG_DEAD_ZONE:      dead_zone_ff      <= DEAD_ZONE_BITS'(csr_wdata);
            REG_SLOW_LIMIT:     slow_sq_ff        <= limit_sq_in;
            REG_MIDDLE_LIMIT:   middle_sq_ff      <= limit_sq_in;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline handshake: each stage moves when the next has room
   // ------------------------------------------------------------------
   logic in_valid_ff, mid_valid_ff, out_valid_ff;
   logic out_ready, mid_ready, in_adv, idle;

   assign out_ready    = !out_valid_ff || rsp_if.ready;
   assign mid_ready    = !mid_valid_ff || out_ready;
   // an idle sample leaves the input stage without needing the next stage
   assign in_adv       = in_valid_ff && (idle || mid_ready);
   assign req_if.ready = !in_valid_ff || in_adv;

   // ------------------------------------------------------------------
   // Input stage
   // ------------------------------------------------------------------
   logic [COORD_BITS-1:0] x_ff, y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         x_ff <= req_if.x_pos;
         y_ff <= req_if.y_pos;
      end
   end

   // ------------------------------------------------------------------
   // Dead zone test, offsets and squares
   // ------------------------------------------------------------------
   logic [COORD_BITS-1:0] nc, xd, yd, ax, ay;
   logic [COORD_BITS-1:0] ref_x_ff, ref_y_ff;
   logic                  xpos, xneg, ypos, yneg;
   logic [SUM_BITS-1:0]   axy_sum;
   logic [S_BITS-1:0]     s_in;
   logic [SQ_BITS-1:0]    ax_sq, ay_sq, xd_sq, yd_sq;
   logic [MAG_BITS-1:0]   mag2_in;

   always_comb begin
      nc   = COORD_BITS'(nominal_center_ff);
      xd   = (x_ff >= nc) ? (x_ff - nc) : (nc - x_ff);
      yd   = (y_ff >= nc) ? (y_ff - nc) : (nc - y_ff);
      idle = (DZ_CMP'(xd) <= DZ_CMP'(dead_zone_ff)) &&
             (DZ_CMP'(yd) <= DZ_CMP'(dead_zone_ff));

      xpos = x_ff > ref_x_ff;
      xneg = x_ff < ref_x_ff;
      ypos = y_ff > ref_y_ff;
      yneg = y_ff < ref_y_ff;
      ax   = xpos ? (x_ff - ref_x_ff) : (ref_x_ff - x_ff);
      ay   = ypos ? (y_ff - ref_y_ff) : (ref_y_ff - y_ff);

      axy_sum = SUM_BITS'(ax) + SUM_BITS'(ay);
      s_in    = S_BITS'(axy_sum) * S_BITS'(axy_sum);
      ax_sq   = SQ_BITS'(ax) * SQ_BITS'(ax);
      ay_sq   = SQ_BITS'(ay) * SQ_BITS'(ay);
      xd_sq   = SQ_BITS'(xd) * SQ_BITS'(xd);
      yd_sq   = SQ_BITS'(yd) * SQ_BITS'(yd);
      mag2_in = MAG_BITS'(xd_sq) + MAG_BITS'(yd_sq);
   end

   // Capture an idle sample as the new reference center
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= REF_RESET;
         ref_y_ff <= REF_RESET;
      end else if (in_adv && idle) begin
         ref_x_ff <= x_ff;
         ref_y_ff <= y_ff;
      end
   end

   // ------------------------------------------------------------------
   // Squares stage
   // ------------------------------------------------------------------
   logic [S_BITS-1:0]   s_ff;
   logic [MAG_BITS-1:0] ax2_ff, ay2_ff, mag2_ff;
   logic                xpos_ff, xneg_ff, ypos_ff, zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (mid_ready) begin
         mid_valid_ff <= in_adv && !idle;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_ready && in_adv && !idle) begin
         s_ff    <= s_in;
         ax2_ff  <= {ax_sq, 1'b0};
         ay2_ff  <= {ay_sq, 1'b0};
         mag2_ff <= mag2_in;
         xpos_ff <= xpos;
         xneg_ff <= xneg;
         ypos_ff <= ypos;
         zero_ff <= !xpos && !xneg && !ypos && !yneg;
      end
   end

   // ------------------------------------------------------------------
   // Sector and speed band
   // ------------------------------------------------------------------
   dir_type   dir_in;
   speed_type speed_in;

   always_comb begin
      if (zero_ff) begin
         dir_in = DIR_RIGHT;
      end else if (CMP_BITS'(s_ff) < CMP_BITS'(ax2_ff)) begin
         dir_in = xpos_ff ? DIR_RIGHT : DIR_LEFT;
      end else if (CMP_BITS'(s_ff) < CMP_BITS'(ay2_ff)) begin
         dir_in = ypos_ff ? DIR_UP : DIR_DOWN;
      end else if (ypos_ff) begin
         dir_in = xpos_ff ? DIR_UP_RIGHT : DIR_UP_LEFT;
      end else begin
         dir_in = xneg_ff ? DIR_DOWN_LEFT : DIR_DOWN_RIGHT;
      end

      if (CMP_BITS'(mag2_ff) < CMP_BITS'(slow_sq_ff)) begin
         speed_in = SPEED_SLOW;
      end else if (CMP_BITS'(mag2_ff) < CMP_BITS'(middle_sq_ff)) begin
         speed_in = SPEED_MIDDLE;
      end else begin
         speed_in = SPEED_FAST;
      end
   end

   // ------------------------------------------------------------------
   // Result stage: hold the item until taken
   // ------------------------------------------------------------------
   dir_type   out_dir_ff;
   speed_type out_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && mid_valid_ff) begin
         out_dir_ff   <= dir_in;
         out_speed_ff <= speed_in;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.direction  = out_dir_ff;
   assign rsp_if.speed_band = out_speed_ff;

endmodule
